/* rtl/rsum_pkg.sv */
`default_nettype none

package rsum_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 48;

  // Request kinds
  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_SUM = 1'b1;

endpackage

`default_nettype wire

/* rtl/rsum_if.sv */
`default_nettype none

interface rsum_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [rsum_pkg::IDX_W-1:0]        elem_index;
  logic signed [rsum_pkg::VAL_W-1:0] elem_value;
  logic [rsum_pkg::IDX_W-1:0]        range_first;
  logic [rsum_pkg::IDX_W-1:0]        range_last;

  modport source (output valid, output req_type, output elem_index, output elem_value,
                  output range_first, output range_last, input ready);
  modport sink   (input valid, input req_type, input elem_index, input elem_value,
                  input range_first, input range_last, output ready);
endinterface

interface rsum_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsum_pkg::SUM_W-1:0] range_total;
  logic                              was_query;

  modport source (output valid, output range_total, output was_query, input ready);
  modport sink   (input valid, input range_total, input was_query, output ready);
endinterface

`default_nettype wire

/* rtl/range_sum_point_update_tree.sv */
// channel | dir | fields                                                   | handshake
// req     | in  | req_type elem_index elem_value range_first range_last    | valid/ready
// res     | out | range_total was_query                                    | valid/ready
//
// One item at a time. An update goes from acceptance through S_ULEAF and S_UWALK to a
// registered result (one tree level per cycle through the single write port); a query
// walks in S_QWALK (one level per cycle, two read ports, two-stage add), then S_QDRAIN.
// After rst the tree memory is zeroed, one entry a cycle, while req.ready stays low.
// A result waiting on res.ready does not block acceptance of the next request; that
// request holds in its final state until the output register frees.

`default_nettype none

module range_sum_point_update_tree #(
  parameter int LEAVES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  rsum_req_if.sink   req,
  rsum_res_if.source res
);

  localparam int AW = $clog2(2 * LEAVES);
  localparam int NW = AW + 1;
  localparam int CW = ((NW > rsum_pkg::IDX_W) ? NW : rsum_pkg::IDX_W) + 1;
  localparam logic [CW-1:0] LEAVES_C  = CW'(LEAVES);
  localparam logic [AW-1:0] LAST_NODE = AW'(2 * LEAVES - 1);
  localparam logic [AW-1:0] ROOT      = AW'(1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ULEAF, S_UWALK, S_QWALK, S_QDRAIN, S_DONE
  } state_t;

  state_t state;

  logic signed [rsum_pkg::SUM_W-1:0] node_sums [2*LEAVES];
  logic signed [rsum_pkg::SUM_W-1:0] rd_a, rd_b;

  logic [AW-1:0]                     clr_addr;
  logic                              is_query;
  logic signed [rsum_pkg::VAL_W-1:0] val;
  logic [AW-1:0]                     node;
  logic signed [rsum_pkg::SUM_W-1:0] cur;
  logic [NW-1:0]                     lo, hi;
  logic signed [rsum_pkg::SUM_W-1:0] acc;
  logic                              en_a_d, en_b_d, pair_v;
  logic signed [rsum_pkg::SUM_W-1:0] pair_sum;
  logic                              res_valid;
  logic signed [rsum_pkg::SUM_W-1:0] res_total;
  logic                              res_wq;

  // memory port control
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic signed [rsum_pkg::SUM_W-1:0] wdata;
  logic [AW-1:0]                     raddr_a, raddr_b;
  logic                              en_a, en_b;

  // request decode
  logic [CW-1:0] first_w, last_w, idx_w, last_c;
  logic          q_empty, idx_ok;
  logic [NW-1:0] lo_init, hi_init;
  logic [AW-1:0] leaf;

  // walk helpers
  logic [AW-1:0]                     parent;
  logic signed [rsum_pkg::SUM_W-1:0] upd_sum;
  logic [NW-1:0]                     hi_m1, lo_next, hi_next;
  logic signed [rsum_pkg::SUM_W-1:0] a_m, b_m;

  assign first_w = CW'(req.range_first);
  assign last_w  = CW'(req.range_last);
  assign idx_w   = CW'(req.elem_index);
  assign last_c  = (last_w >= LEAVES_C) ? LEAVES_C - CW'(1) : last_w;
  assign q_empty = first_w > last_c;
  assign lo_init = NW'(first_w + LEAVES_C);
  assign hi_init = NW'(last_c + LEAVES_C + CW'(1));
  assign idx_ok  = idx_w < LEAVES_C;
  assign leaf    = AW'(idx_w + LEAVES_C);

  assign parent  = node >> 1;
  assign upd_sum = cur + rd_a;
  assign hi_m1   = hi - NW'(1);
  assign lo_next = (lo + NW'(lo[0])) >> 1;
  assign hi_next = (hi - NW'(hi[0])) >> 1;
  assign a_m     = en_a_d ? rd_a : '0;
  assign b_m     = en_b_d ? rd_b : '0;

  always_comb begin
    we      = 1'b0;
    waddr   = node;
    wdata   = cur;
    raddr_a = node ^ ROOT;
    raddr_b = hi_m1[AW-1:0];
    en_a    = 1'b0;
    en_b    = 1'b0;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      S_ULEAF: begin
        // write the leaf, fetch its sibling
        we    = 1'b1;
        waddr = node;
        wdata = rsum_pkg::SUM_W'(val);
      end
      S_UWALK: begin
        we      = 1'b1;
        waddr   = parent;
        wdata   = upd_sum;
        raddr_a = parent ^ ROOT;
      end
      S_QWALK: begin
        en_a    = lo[0];
        raddr_a = lo[AW-1:0];
        en_b    = hi[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      node_sums[waddr] <= wdata;
    end
    rd_a <= node_sums[raddr_a];
    rd_b <= node_sums[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      en_a_d    <= 1'b0;
      en_b_d    <= 1'b0;
      pair_v    <= 1'b0;
    end else begin
      en_a_d   <= en_a;
      en_b_d   <= en_b;
      pair_v   <= en_a_d | en_b_d;
      pair_sum <= a_m + b_m;
      if (pair_v) begin
        acc <= acc + pair_sum;
      end
      if (res.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_NODE) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            is_query <= (req.req_type == rsum_pkg::REQ_SUM);
            acc      <= '0;
            lo       <= lo_init;
            hi       <= hi_init;
            node     <= leaf;
            val      <= req.elem_value;
            if (req.req_type == rsum_pkg::REQ_SUM) begin
              state <= q_empty ? S_DONE : S_QWALK;
            end else begin
              state <= idx_ok ? S_ULEAF : S_DONE;
            end
          end
        end
        S_ULEAF: begin
          cur   <= rsum_pkg::SUM_W'(val);
          state <= S_UWALK;
        end
        S_UWALK: begin
          cur  <= upd_sum;
          node <= parent;
          if (parent <= ROOT) begin
            state <= S_DONE;
          end
        end
        S_QWALK: begin
          lo <= lo_next;
          hi <= hi_next;
          if (lo_next >= hi_next) begin
            state <= S_QDRAIN;
          end
        end
        S_QDRAIN: begin
          // wait until the last reads are folded into acc
          if (!en_a_d && !en_b_d && !pair_v) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_total <= is_query ? acc : '0;
            res_wq    <= is_query;
            state     <= S_IDLE;
          end else if (res.ready) begin
            res_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign res.valid       = res_valid;
  assign res.range_total = res_total;
  assign res.was_query   = res_wq;

endmodule

`default_nettype wire

/* rtl/rsum_check.sv */
`default_nettype none

module rsum_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [rsum_pkg::SUM_W-1:0] res_range_total,
  input logic                       res_was_query
);

  // a pending result holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_range_total)
                                && $stable(res_was_query))
    else $error("result changed or dropped while stalled");

  // updates answer with zero
  a_upd_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_was_query |-> res_range_total == '0)
    else $error("update result carries a nonzero total");

  // the clearing pass keeps requests out right after reset
  a_clear: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken during clearing pass");

  // one item in flight: no back-to-back request transactions
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an item is in progress");

endmodule

bind range_sum_point_update_tree rsum_check u_rsum_check (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_range_total (res.range_total),
  .res_was_query   (res.was_query)
);

`default_nettype wire
